// ===== hdl/mdf_pkg.sv =====
// mdf_pkg: shared operation codes and controller/datapath command and status
// types for the multiply, divide and flags unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

    // operation codes
    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_IMUL = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_IDIV = 3'd3;
    localparam logic [2:0] OP_COND = 3'd4;
    localparam logic [2:0] OP_LOAD = 3'd5;
    localparam logic [2:0] OP_CLR  = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the input word
        logic mul_go;    // register the product
        logic div_load;  // set up magnitudes for the divider
        logic div_chk;   // quotient-overflow precheck
        logic div_step;  // one restoring quotient bit
        logic load_out;  // commit result and flags
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic word;       // word-size operands
        logic chk_fault;  // divide fault known before iterating
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/mdf_ctrl.sv =====
// mdf_ctrl: sequencing state machine for the multiply, divide and flags unit.
// Depends on mdf_pkg (command and status types, operation codes).
`timescale 1ns / 1ps
`default_nettype none

module mdf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [2:0]      i_operation,
    input  wire logic            i_out_stall,
    input  wire mdf_pkg::t_dp_sts i_sts,
    output mdf_pkg::t_dp_cmd     o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import mdf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DLOAD,
        S_DCHK,
        S_DIV,
        S_FIN
    } t_state;

    localparam logic [3:0] LAST_WORD = 4'd15;
    localparam logic [3:0] LAST_BYTE = 4'd7;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_out_valid;
    logic       out_free;
    logic [3:0] last_step;
    t_dp_cmd    cmd;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = i_sts.word ? LAST_WORD : LAST_BYTE;

    always_comb begin
        cmd         = '0;
        cmd.load_in = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_MUL:   cmd.mul_go   = 1'b1;
            S_DLOAD: cmd.div_load = 1'b1;
            S_DCHK:  cmd.div_chk  = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_FIN:   cmd.load_out = out_free;
            default: cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_operation inside {OP_MUL, OP_IMUL}) begin
                            r_state <= S_MUL;
                        end else if (i_operation inside {OP_DIV, OP_IDIV}) begin
                            r_state <= S_DLOAD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL:   r_state <= S_FIN;
                S_DLOAD: r_state <= S_DCHK;
                S_DCHK: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.chk_fault ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == last_step) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !cmd.load_out)
        else $error("result overwritten while stalled");

    // one item at a time: an accepted word closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not closed after accept");

    // step counter stays within the operand width
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= last_step))
        else $error("divide step count out of range");

    // a precheck fault skips the iterations
    a_fault_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DCHK && i_sts.chk_fault) |=> (r_state == S_FIN))
        else $error("faulted divide iterated");

endmodule

`default_nettype wire

// ===== hdl/mdf_dpath.sv =====
// mdf_dpath: operand registers, multiplier, restoring divider, flag register
// and result registers. Depends on mdf_pkg; driven by mdf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mdf_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mdf_pkg::t_dp_cmd i_cmd,
    output mdf_pkg::t_dp_sts      o_sts,
    input  wire logic [2:0]       i_operation,
    input  wire logic             i_word_size,
    input  wire logic [15:0]      i_high_in,
    input  wire logic [15:0]      i_low_in,
    input  wire logic [15:0]      i_source,
    input  wire logic [3:0]       i_cond_code,
    input  wire logic [15:0]      i_flags_in,
    output logic [15:0]           o_high_out,
    output logic [15:0]           o_low_out,
    output logic                  o_divide_error,
    output logic                  o_cond_true,
    output logic [15:0]           o_flags_out
);
    import mdf_pkg::*;

    // internal flag order: C P A Z S T I D O
    localparam int FB_C = 0;
    localparam int FB_P = 1;
    localparam int FB_Z = 3;
    localparam int FB_S = 4;
    localparam int FB_O = 8;

    // condition pairs, selected by code[3:1]
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_C  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    logic [2:0]  r_op;
    logic        r_word;
    logic [15:0] r_hi, r_lo, r_src, r_fin;
    logic [3:0]  r_cc;
    logic [31:0] r_prod;
    logic [15:0] r_rem, r_shf, r_den, r_quo;
    logic        r_nneg, r_qneg, r_fault;
    logic [8:0]  r_flags;
    logic [15:0] r_high_out, r_low_out, r_flags_out;
    logic        r_divide_error, r_cond_true;

    logic [15:0] in_mask, res_mask;
    logic        is_signed;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_full;
    logic [31:0] num32, num_abs;
    logic [15:0] den16, den_abs;
    logic        nneg, dneg;
    logic        chk_fault;
    logic [16:0] trial, rem_sub;
    logic        take;
    logic [15:0] prod_hi, prod_lo, q_lim, q_sgn, r_sgn;
    logic        lo_sign, mul_sig, rng_fault, div_fault, cc_raw;
    logic [15:0] n_high, n_low;
    logic        n_derr, n_ct;
    logic [8:0]  n_flags;

    assign in_mask   = i_word_size ? 16'hFFFF : 16'h00FF;
    assign res_mask  = r_word ? 16'hFFFF : 16'h00FF;
    assign is_signed = (r_op == OP_IMUL) || (r_op == OP_IDIV);

    // multiplier operands, zero or sign extended to 17 bits
    always_comb begin
        if (r_word) begin
            mul_a = {is_signed & r_lo[15], r_lo};
            mul_b = {is_signed & r_src[15], r_src};
        end else begin
            mul_a = {{9{is_signed & r_lo[7]}}, r_lo[7:0]};
            mul_b = {{9{is_signed & r_src[7]}}, r_src[7:0]};
        end
    end
    assign mul_full = mul_a * mul_b;

    // divider set-up: magnitudes of dividend and divisor
    assign num32   = r_word ? {r_hi, r_lo}
                            : {{16{is_signed & r_hi[7]}}, r_hi[7:0], r_lo[7:0]};
    assign nneg    = is_signed & num32[31];
    assign num_abs = nneg ? (32'd0 - num32) : num32;
    assign den16   = r_word ? r_src : {{8{is_signed & r_src[7]}}, r_src[7:0]};
    assign dneg    = is_signed & den16[15];
    assign den_abs = dneg ? (16'd0 - den16) : den16;

    // quotient fits only if the high part is below the divisor (zero divisor too)
    assign chk_fault = (r_rem >= r_den);

    assign trial   = {r_rem, r_shf[15]};
    assign rem_sub = trial - {1'b0, r_den};
    assign take    = (trial >= {1'b0, r_den});

    // result forming
    assign prod_hi = r_word ? r_prod[31:16] : {8'h00, r_prod[15:8]};
    assign prod_lo = r_word ? r_prod[15:0]  : {8'h00, r_prod[7:0]};
    assign lo_sign = r_word ? prod_lo[15] : prod_lo[7];
    assign mul_sig = (r_op == OP_IMUL) ? (prod_hi != (lo_sign ? res_mask : 16'h0000))
                                       : (prod_hi != 16'h0000);

    assign q_lim     = r_word ? (r_qneg ? 16'h8000 : 16'h7FFF)
                              : (r_qneg ? 16'h0080 : 16'h007F);
    assign rng_fault = is_signed && (r_quo > q_lim);
    assign div_fault = r_fault || rng_fault;
    assign q_sgn     = (r_qneg ? (16'd0 - r_quo) : r_quo) & res_mask;
    assign r_sgn     = (r_nneg ? (16'd0 - r_rem) : r_rem) & res_mask;

    always_comb begin
        case (r_cc[3:1])
            CC_O:    cc_raw = r_flags[FB_O];
            CC_C:    cc_raw = r_flags[FB_C];
            CC_Z:    cc_raw = r_flags[FB_Z];
            CC_BE:   cc_raw = r_flags[FB_C] | r_flags[FB_Z];
            CC_S:    cc_raw = r_flags[FB_S];
            CC_P:    cc_raw = r_flags[FB_P];
            CC_L:    cc_raw = r_flags[FB_S] ^ r_flags[FB_O];
            CC_LE:   cc_raw = r_flags[FB_Z] | (r_flags[FB_S] ^ r_flags[FB_O]);
            default: cc_raw = 1'b0;
        endcase
    end

    always_comb begin
        n_high  = 16'h0000;
        n_low   = 16'h0000;
        n_derr  = 1'b0;
        n_ct    = 1'b0;
        n_flags = r_flags;
        case (r_op)
            OP_MUL, OP_IMUL: begin
                n_high        = prod_hi;
                n_low         = prod_lo;
                n_flags[FB_C] = mul_sig;
                n_flags[FB_O] = mul_sig;
            end
            OP_DIV, OP_IDIV: begin
                if (div_fault) begin
                    n_derr = 1'b1;
                    n_high = r_hi;
                    n_low  = r_lo;
                end else begin
                    n_high = r_sgn;
                    n_low  = q_sgn;
                end
            end
            OP_COND: n_ct = cc_raw ^ r_cc[0];
            OP_LOAD: begin
                // byte load takes only C P A Z S
                if (r_word) begin
                    n_flags = {r_fin[11], r_fin[10], r_fin[9], r_fin[8], r_fin[7],
                               r_fin[6], r_fin[4], r_fin[2], r_fin[0]};
                end else begin
                    n_flags = {r_flags[8:5], r_fin[7], r_fin[6], r_fin[4],
                               r_fin[2], r_fin[0]};
                end
            end
            OP_CLR:  n_flags = '0;
            default: n_flags = r_flags;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmd.load_out) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_operation;
            r_word <= i_word_size;
            r_hi   <= i_high_in & in_mask;
            r_lo   <= i_low_in & in_mask;
            r_src  <= i_source & in_mask;
            r_cc   <= i_cond_code;
            r_fin  <= i_flags_in;
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_full[31:0];
        end
        if (i_cmd.div_load) begin
            r_rem  <= r_word ? num_abs[31:16] : {8'h00, num_abs[15:8]};
            r_shf  <= r_word ? num_abs[15:0] : {num_abs[7:0], 8'h00};
            r_den  <= den_abs;
            r_nneg <= nneg;
            r_qneg <= nneg ^ dneg;
            r_quo  <= '0;
        end
        if (i_cmd.div_chk) begin
            r_fault <= chk_fault;
        end
        if (i_cmd.div_step) begin
            r_rem <= take ? rem_sub[15:0] : trial[15:0];
            r_shf <= {r_shf[14:0], 1'b0};
            r_quo <= {r_quo[14:0], take};
        end
        if (i_cmd.load_out) begin
            r_high_out     <= n_high;
            r_low_out      <= n_low;
            r_divide_error <= n_derr;
            r_cond_true    <= n_ct;
            // bit 1 reads as one, reserved bits as zero
            r_flags_out    <= {4'h0, n_flags[8:4], n_flags[3], 1'b0, n_flags[2],
                               1'b0, n_flags[1], 1'b1, n_flags[0]};
        end
    end

    assign o_sts.word      = r_word;
    assign o_sts.chk_fault = chk_fault;

    assign o_high_out     = r_high_out;
    assign o_low_out      = r_low_out;
    assign o_divide_error = r_divide_error;
    assign o_cond_true    = r_cond_true;
    assign o_flags_out    = r_flags_out;

endmodule

`default_nettype wire

// ===== hdl/x86_muldiv_flags_unit_top.sv =====
// An accepted multiply passes S_MUL, a divide S_DLOAD, S_DCHK and the steps of
// the restoring divider (one quotient bit per cycle); a condition test, flag
// load, flag clear or any other code goes straight to S_FIN, which registers the
// result. A divide that faults in its precheck skips the steps. One word is in
// work at a time; the next is taken the cycle after the result is registered.
// Reset (i_rst_n low, synchronous) clears the flags, the sequencer and o_out_valid.
`timescale 1ns / 1ps
`default_nettype none

module x86_muldiv_flags_unit_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic        i_word_size,
    input  wire logic [15:0] i_high_in,
    input  wire logic [15:0] i_low_in,
    input  wire logic [15:0] i_source,
    input  wire logic [3:0]  i_cond_code,
    input  wire logic [15:0] i_flags_in,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_high_out,
    output logic [15:0]      o_low_out,
    output logic             o_divide_error,
    output logic             o_cond_true,
    output logic [15:0]      o_flags_out
);
    import mdf_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: picks the path from the operation, counts divide steps and
    // owns the result-valid register, so a finished word may sit at the
    // output while the next word is taken and worked on
    mdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // datapath: 17x17 signed multiplier (registered product), magnitude
    // restoring divider with sign fix-up and range check, flag register and
    // the result registers
    mdf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_operation),
        .i_word_size    (i_word_size),
        .i_high_in      (i_high_in),
        .i_low_in       (i_low_in),
        .i_source       (i_source),
        .i_cond_code    (i_cond_code),
        .i_flags_in     (i_flags_in),
        .o_high_out     (o_high_out),
        .o_low_out      (o_low_out),
        .o_divide_error (o_divide_error),
        .o_cond_true    (o_cond_true),
        .o_flags_out    (o_flags_out)
    );

endmodule

`default_nettype wire

// ===== test/x86_muldiv_flags_unit_checker.sv =====
// Result checker for the multiply, divide and flags unit: predicts every
// accepted word from its own flag copy and compares the results in order.
// Depends on mdf_pkg for the operation codes.
`timescale 1ns / 1ps

module x86_muldiv_flags_unit_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic        i_word_size,
    input  wire logic [15:0] i_high_in,
    input  wire logic [15:0] i_low_in,
    input  wire logic [15:0] i_source,
    input  wire logic [3:0]  i_cond_code,
    input  wire logic [15:0] i_flags_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_high_out,
    input  wire logic [15:0] i_low_out,
    input  wire logic        i_divide_error,
    input  wire logic        i_cond_true,
    input  wire logic [15:0] i_flags_out,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results,
    output int               o_div_faults
);
    import mdf_pkg::*;

    // internal flag order
    localparam int FL_C = 0;
    localparam int FL_P = 1;
    localparam int FL_A = 2;
    localparam int FL_Z = 3;
    localparam int FL_S = 4;
    localparam int FL_T = 5;
    localparam int FL_I = 6;
    localparam int FL_D = 7;
    localparam int FL_O = 8;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
        logic        div_err;
        logic        cond;
        logic [15:0] flags;
    } mdf_result_t;

    logic [8:0]  flag_reg;
    mdf_result_t pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          faults_predicted = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_div_faults = 0;
        flag_reg     = '0;
    end

    function automatic longint signed_of(input logic [31:0] v, input int bits);
        case (bits)
            8:       return longint'($signed(v[7:0]));
            16:      return longint'($signed(v[15:0]));
            default: return longint'($signed(v[31:0]));
        endcase
    endfunction

    function automatic logic [15:0] packed_flags(input logic [8:0] f);
        return {4'b0, f[FL_O], f[FL_D], f[FL_I], f[FL_T], f[FL_S], f[FL_Z], 1'b0,
                f[FL_A], 1'b0, f[FL_P], 1'b1, f[FL_C]};
    endfunction

    // Works out the result of one word and moves the flag copy on.
    function automatic mdf_result_t compute_muldiv_result(
        input logic [2:0]  op,
        input logic        word,
        input logic [15:0] hi_f,
        input logic [15:0] lo_f,
        input logic [15:0] src_f,
        input logic [3:0]  cc,
        input logic [15:0] fl_in
    );
        mdf_result_t r;
        int          bits;
        logic [15:0] mask, hi, lo, src;
        logic [31:0] prod, dividend, uq;
        longint      sp, n, d, sq, sr, qmax;
        logic        sig, fault, cond;
        r    = '0;
        bits = word ? 16 : 8;
        mask = word ? 16'hffff : 16'h00ff;
        hi   = hi_f & mask;
        lo   = lo_f & mask;
        src  = src_f & mask;
        case (op)
            OP_MUL, OP_IMUL: begin
                if (op == OP_MUL) begin
                    prod = {16'h0, lo} * {16'h0, src};
                end else begin
                    sp   = signed_of(lo, bits) * signed_of(src, bits);
                    prod = sp[31:0];
                end
                r.high = 16'(prod >> bits) & mask;
                r.low  = prod[15:0] & mask;
                if (op == OP_MUL)
                    sig = (r.high != 16'h0);
                else
                    sig = (r.high != (r.low[bits-1] ? mask : 16'h0));
                flag_reg[FL_C] = sig;
                flag_reg[FL_O] = sig;
            end
            OP_DIV, OP_IDIV: begin
                dividend = word ? {hi, lo} : {16'h0, hi[7:0], lo[7:0]};
                fault    = (src == 16'h0);
                if (!fault && op == OP_DIV) begin
                    uq = dividend / {16'h0, src};
                    if (uq > {16'h0, mask}) begin
                        fault = 1'b1;
                    end else begin
                        r.low  = uq[15:0];
                        r.high = 16'(dividend % {16'h0, src});
                    end
                end else if (!fault) begin
                    // truncating divide, remainder follows the dividend's sign
                    n    = signed_of(dividend, 2 * bits);
                    d    = signed_of({16'h0, src}, bits);
                    sq   = n / d;
                    sr   = n % d;
                    qmax = word ? 32767 : 127;
                    if (sq > qmax || sq < -qmax - 1) begin
                        fault = 1'b1;
                    end else begin
                        r.low  = sq[15:0] & mask;
                        r.high = sr[15:0] & mask;
                    end
                end
                if (fault) begin
                    r.div_err = 1'b1;
                    r.high    = hi;
                    r.low     = lo;
                end
            end
            OP_COND: begin
                case (cc[3:1])
                    3'd0:    cond = flag_reg[FL_O];
                    3'd1:    cond = flag_reg[FL_C];
                    3'd2:    cond = flag_reg[FL_Z];
                    3'd3:    cond = flag_reg[FL_C] | flag_reg[FL_Z];
                    3'd4:    cond = flag_reg[FL_S];
                    3'd5:    cond = flag_reg[FL_P];
                    3'd6:    cond = flag_reg[FL_S] ^ flag_reg[FL_O];
                    default: cond = flag_reg[FL_Z] | (flag_reg[FL_S] ^ flag_reg[FL_O]);
                endcase
                r.cond = cond ^ cc[0];
            end
            OP_LOAD: begin
                flag_reg[FL_C] = fl_in[0];
                flag_reg[FL_P] = fl_in[2];
                flag_reg[FL_A] = fl_in[4];
                flag_reg[FL_Z] = fl_in[6];
                flag_reg[FL_S] = fl_in[7];
                if (word) begin
                    flag_reg[FL_T] = fl_in[8];
                    flag_reg[FL_I] = fl_in[9];
                    flag_reg[FL_D] = fl_in[10];
                    flag_reg[FL_O] = fl_in[11];
                end
            end
            OP_CLR: flag_reg = '0;
            default: ;
        endcase
        r.flags = packed_flags(flag_reg);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        mdf_result_t want;
        if (!i_rst_n) begin
            flag_reg = '0;
            pending_results.delete();
        end else begin
            // result side first: a word taken at this edge cannot have its result yet
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual %h %h %b %b %h",
                             $time, i_high_out, i_low_out, i_divide_error, i_cond_true,
                             i_flags_out);
                end else begin
                    want = pending_results.pop_front();
                    check_field("high_out", want.high, i_high_out);
                    check_field("low_out", want.low, i_low_out);
                    check_field("divide_error", 16'(want.div_err), 16'(i_divide_error));
                    check_field("cond_true", 16'(want.cond), 16'(i_cond_true));
                    check_field("flags_out", want.flags, i_flags_out);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = compute_muldiv_result(i_operation, i_word_size, i_high_in, i_low_in,
                                             i_source, i_cond_code, i_flags_in);
                if (want.div_err)
                    faults_predicted++;
                pending_results.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
        o_results    <= results_seen;
        o_div_faults <= faults_predicted;
    end

endmodule

// ===== test/x86_muldiv_flags_unit_top_tb.sv =====
// Testbench top for the multiply, divide and flags unit: drives directed and
// random words, stalls the result side, gives the verdict.
// Depends on mdf_pkg, x86_muldiv_flags_unit_top and x86_muldiv_flags_unit_checker.
`timescale 1ns / 1ps

module x86_muldiv_flags_unit_top_tb;
    import mdf_pkg::*;

    // operation code 7 has no name in the package; the block must ignore it
    localparam logic [2:0] OP_SPARE = 3'd7;

    localparam int RANDOM_WORDS = 1330;
    localparam int QUIET_TAIL   = 150;   // last words sent with no idling at all
    localparam int HOLD_AT      = 400;   // words sent before the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct {
        logic [2:0]  op;
        logic        sz;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] src;
        logic [3:0]  cc;
        logic [15:0] fl;
    } mdf_word_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_operation = '0;
    logic        i_word_size = 1'b0;
    logic [15:0] i_high_in   = '0;
    logic [15:0] i_low_in    = '0;
    logic [15:0] i_source    = '0;
    logic [3:0]  i_cond_code = '0;
    logic [15:0] i_flags_in  = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_high_out;
    logic [15:0] o_low_out;
    logic        o_divide_error;
    logic        o_cond_true;
    logic [15:0] o_flags_out;

    int fail_count;
    int pending;
    int results_checked;
    int div_faults;

    // word source state; words_sent and tail_quiet are shared with the result sink
    int   words_sent = 0;
    int   op_count[8];
    logic tail_quiet = 1'b0;
    logic sender_calm = 1'b0;

    always #5 i_clk = ~i_clk;

    x86_muldiv_flags_unit_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_word_size    (i_word_size),
        .i_high_in      (i_high_in),
        .i_low_in       (i_low_in),
        .i_source       (i_source),
        .i_cond_code    (i_cond_code),
        .i_flags_in     (i_flags_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_high_out     (o_high_out),
        .o_low_out      (o_low_out),
        .o_divide_error (o_divide_error),
        .o_cond_true    (o_cond_true),
        .o_flags_out    (o_flags_out)
    );

    x86_muldiv_flags_unit_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_word_size    (i_word_size),
        .i_high_in      (i_high_in),
        .i_low_in       (i_low_in),
        .i_source       (i_source),
        .i_cond_code    (i_cond_code),
        .i_flags_in     (i_flags_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_high_out     (o_high_out),
        .i_low_out      (o_low_out),
        .i_divide_error (o_divide_error),
        .i_cond_true    (o_cond_true),
        .i_flags_out    (o_flags_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (results_checked),
        .o_div_faults   (div_faults)
    );

    function automatic mdf_word_t word_of(input logic [2:0] op, input logic sz,
                                          input logic [15:0] hi, input logic [15:0] lo,
                                          input logic [15:0] src, input logic [3:0] cc,
                                          input logic [15:0] fl);
        mdf_word_t w;
        w.op  = op;
        w.sz  = sz;
        w.hi  = hi;
        w.lo  = lo;
        w.src = src;
        w.cc  = cc;
        w.fl  = fl;
        return w;
    endfunction

    // A divide built from divisor, quotient and remainder, so that it always
    // gets through the range check and exercises the full iteration. In byte
    // mode the ignored upper bytes stay random.
    function automatic mdf_word_t clean_divide(input logic sgn, input logic sz);
        mdf_word_t w;
        longint    q, d, r, n, qmax, dmag;
        w = word_of(sgn ? OP_IDIV : OP_DIV, sz, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        if (!sgn) begin
            d = $urandom_range(1, sz ? 65535 : 255);
            q = $urandom_range(0, sz ? 65535 : 255);
            r = $urandom_range(0, int'(d - 1));
        end else begin
            qmax = sz ? 32767 : 127;
            d    = 0;
            while (d == 0)
                d = longint'($urandom_range(0, int'(2 * qmax + 1))) - qmax - 1;
            q    = longint'($urandom_range(0, int'(2 * qmax + 1))) - qmax - 1;
            dmag = (d < 0) ? -d : d;
            r    = $urandom_range(0, int'(dmag - 1));
            // remainder must share the dividend's sign for truncation to give q
            if (q * d < 0 || (q == 0 && $urandom_range(0, 1) == 0))
                r = -r;
        end
        n = q * d + r;
        if (sz) begin
            w.hi  = n[31:16];
            w.lo  = n[15:0];
            w.src = d[15:0];
        end else begin
            w.hi[7:0]  = n[15:8];
            w.lo[7:0]  = n[7:0];
            w.src[7:0] = d[7:0];
        end
        return w;
    endfunction

    // Offers one word and waits for it to be taken. Valid is only lowered for
    // an idle burst, never in the step that raises it again.
    task automatic send_word(input mdf_word_t w);
        if (!tail_quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= w.op;
        i_word_size <= w.sz;
        i_high_in   <= w.hi;
        i_low_in    <= w.lo;
        i_source    <= w.src;
        i_cond_code <= w.cc;
        i_flags_in  <= w.fl;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        op_count[w.op]++;
    endtask

    // Result sink: random stall bursts, free-running stretches, one long
    // hold-off to back the block up, and no stalls at all in the tail.
    initial begin : result_sink
        int   held;
        logic hold_done;
        hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && words_sent >= HOLD_AT) begin
                i_out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
                hold_done = 1'b1;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (tail_quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b0;
                repeat (64) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin : word_source
        mdf_word_t w;
        int        k, idx, drain;
        logic      sz;
        foreach (op_count[j])
            op_count[j] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed words ---
        // multiply: full-scale byte and word, zero product clears CF/OF
        send_word(word_of(OP_MUL, 1'b0, $urandom, 16'ha5ff, 16'h3cff, $urandom, $urandom));
        send_word(word_of(OP_MUL, 1'b1, $urandom, 16'hffff, 16'hffff, $urandom, $urandom));
        send_word(word_of(OP_MUL, 1'b1, $urandom, 16'h0000, 16'h1234, $urandom, $urandom));
        // signed multiply: -128 squared, -1 fits, +32768 overflows a word
        send_word(word_of(OP_IMUL, 1'b0, $urandom, 16'h0080, 16'h0080, $urandom, $urandom));
        send_word(word_of(OP_IMUL, 1'b0, $urandom, 16'h00ff, 16'h0001, $urandom, $urandom));
        send_word(word_of(OP_IMUL, 1'b1, $urandom, 16'h8000, 16'hffff, $urandom, $urandom));
        // unsigned divide: zero divisor, quotient overflow, largest quotient
        send_word(word_of(OP_DIV, 1'b1, 16'h1234, 16'h5678, 16'h0000, $urandom, $urandom));
        send_word(word_of(OP_DIV, 1'b0, 16'h00ff, 16'h0000, 16'h0002, $urandom, $urandom));
        send_word(word_of(OP_DIV, 1'b1, 16'hfffe, 16'hffff, 16'hffff, $urandom, $urandom));
        // signed divide: most negative over -1, range edges, negative remainder, zero divisor
        send_word(word_of(OP_IDIV, 1'b1, 16'h8000, 16'h0000, 16'hffff, $urandom, $urandom));
        send_word(word_of(OP_IDIV, 1'b0, 16'h00ff, 16'h0080, 16'h0001, $urandom, $urandom));
        send_word(word_of(OP_IDIV, 1'b0, 16'h00ff, 16'h0080, 16'h00ff, $urandom, $urandom));
        send_word(word_of(OP_IDIV, 1'b0, 16'h00ff, 16'h00f9, 16'h0002, $urandom, $urandom));
        send_word(word_of(OP_IDIV, 1'b1, 16'hffff, 16'hfff0, 16'h0000, $urandom, $urandom));
        // word load sets every flag, byte load only touches C P A Z S
        send_word(word_of(OP_LOAD, 1'b1, $urandom, $urandom, $urandom, $urandom, 16'hffff));
        send_word(word_of(OP_COND, $urandom, $urandom, $urandom, $urandom, 4'd0, $urandom));
        send_word(word_of(OP_COND, $urandom, $urandom, $urandom, $urandom, 4'd13, $urandom));
        send_word(word_of(OP_LOAD, 1'b0, $urandom, $urandom, $urandom, $urandom, 16'h0000));
        send_word(word_of(OP_COND, $urandom, $urandom, $urandom, $urandom, 4'd12, $urandom));
        send_word(word_of(OP_COND, $urandom, $urandom, $urandom, $urandom, 4'd15, $urandom));
        send_word(word_of(OP_CLR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        send_word(word_of(OP_COND, $urandom, $urandom, $urandom, $urandom, 4'd7, $urandom));
        send_word(word_of(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom));

        // --- random words ---
        for (idx = 0; idx < RANDOM_WORDS; idx++) begin
            if (idx % 50 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            if (idx == RANDOM_WORDS - QUIET_TAIL)
                tail_quiet = 1'b1;
            sz = $urandom_range(0, 1);
            k  = $urandom_range(0, 99);
            w  = word_of(OP_MUL, sz, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (k < 14) begin
                w.op = OP_MUL;
            end else if (k < 28) begin
                w.op = OP_IMUL;
            end else if (k < 48) begin
                w = clean_divide($urandom_range(0, 1), sz);
            end else if (k < 58) begin
                // raw divide: mostly faults, sometimes a zero divisor
                w.op = ($urandom_range(0, 1) == 0) ? OP_DIV : OP_IDIV;
                if ($urandom_range(0, 3) == 0)
                    w.src = 16'h0000;
            end else if (k < 80) begin
                w.op = OP_COND;
            end else if (k < 91) begin
                w.op = OP_LOAD;
            end else if (k < 97) begin
                w.op = OP_CLR;
            end else begin
                w.op = OP_SPARE;
            end
            send_word(w);
        end
        i_in_valid <= 1'b0;

        // let every outstanding result come back, then a margin for strays
        drain = 0;
        do begin
            @(posedge i_clk);
            drain++;
        end while (pending != 0 && drain < DRAIN_LIMIT);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d words: mul %0d, imul %0d, div %0d, idiv %0d, cond %0d, load %0d, clear %0d, spare %0d",
                 words_sent, op_count[OP_MUL], op_count[OP_IMUL], op_count[OP_DIV],
                 op_count[OP_IDIV], op_count[OP_COND], op_count[OP_LOAD], op_count[OP_CLR],
                 op_count[OP_SPARE]);
        $display("Checked %0d results, %0d divide faults among them, %0d still outstanding, %0d mismatches",
                 results_checked, div_faults, pending, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Timeout: %0d words sent, %0d results outstanding", words_sent, pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mdf_pkg.sv
hdl/mdf_ctrl.sv
hdl/mdf_dpath.sv
hdl/x86_muldiv_flags_unit_top.sv
test/x86_muldiv_flags_unit_checker.sv
test/x86_muldiv_flags_unit_top_tb.sv
